### src/iss_pkg.sv
// iss_pkg: shared types and operation codes of the indexed sequence store
// no dependencies
package iss_pkg;

   localparam logic [2:0] OP_INSERT  = 3'd0;
   localparam logic [2:0] OP_REMOVE  = 3'd1;
   localparam logic [2:0] OP_GET     = 3'd2;
   localparam logic [2:0] OP_PREPEND = 3'd3;
   localparam logic [2:0] OP_APPEND  = 3'd4;

   localparam int POS_WIDTH = 16;

   typedef struct packed {
      logic [2:0]            op;
      logic signed [15:0]    position;
      logic [31:0]           value;
   } req_type;

   typedef struct packed {
      logic        ok;
      logic [31:0] read_value;
      logic [8:0]  length;
   } rsp_type;

   typedef struct packed {
      logic        start;
      logic [15:0] dividend;
   } div_ctl_type;

endpackage

### src/iss_mod_unit.sv
// iss_mod_unit: restoring remainder unit, one dividend bit per cycle
// depends on iss_pkg
module iss_mod_unit #(
   parameter int CW = 9
) (
   input  logic                 clock,
   input  logic                 reset,
   input  iss_pkg::div_ctl_type ctl,
   input  logic [CW-1:0]        divisor,
   output logic                 done,
   output logic [CW-1:0]        remainder
);

   localparam int SW = $clog2(iss_pkg::POS_WIDTH + 1);

   logic [SW-1:0] steps_ff, steps_in;
   logic [15:0]   num_ff, num_in;
   logic [CW-1:0] rem_ff, rem_in;
   logic          done_ff, done_in;
   logic [CW:0]   shifted;

   always_comb begin
      shifted  = {rem_ff, num_ff[15]};
      steps_in = steps_ff;
      num_in   = num_ff;
      rem_in   = rem_ff;
      done_in  = 1'b0;
      if (ctl.start) begin
         steps_in = SW'(iss_pkg::POS_WIDTH);
         num_in   = ctl.dividend;
         rem_in   = '0;
      end else if (steps_ff != '0) begin
         num_in   = {num_ff[14:0], 1'b0};
         steps_in = steps_ff - SW'(1);
         if (shifted >= {1'b0, divisor}) begin
            rem_in = CW'(shifted - {1'b0, divisor});
         end else begin
            rem_in = CW'(shifted);
         end
         done_in = (steps_ff == SW'(1));
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         steps_ff <= '0;
         done_ff  <= 1'b0;
      end else begin
         steps_ff <= steps_in;
         done_ff  <= done_in;
      end
      num_ff <= num_in;
      rem_ff <= rem_in;
   end

   assign done      = done_ff;
   assign remainder = rem_ff;

endmodule

### src/indexed_sequence_store.sv
// indexed_sequence_store: ordered sequence of up to CAPACITY values in one memory
// insert: shift up, write; remove: read, shift down; get: modulo, read; others: reply only
// one beat at a time; the shift sweep (one read and one write per moved entry) sets the rate
// reset clears the length and all control; memory contents stay undefined until written
// depends on iss_pkg and iss_mod_unit
module indexed_sequence_store #(
   parameter int CAPACITY    = 256,
   parameter int VALUE_WIDTH = 32
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_valid,
   output logic             req_stall,
   input  iss_pkg::req_type req_data,
   output logic             rsp_valid,
   input  logic             rsp_stall,
   output iss_pkg::rsp_type rsp_data
);

   localparam int AW = $clog2(CAPACITY);
   localparam int CW = $clog2(CAPACITY + 1);

   localparam logic [3:0] ST_IDLE    = 4'd0;
   localparam logic [3:0] ST_SH_RD   = 4'd1;
   localparam logic [3:0] ST_SH_WR   = 4'd2;
   localparam logic [3:0] ST_WR_NEW  = 4'd3;
   localparam logic [3:0] ST_RM_RD   = 4'd4;
   localparam logic [3:0] ST_RM_CAP  = 4'd5;
   localparam logic [3:0] ST_RM_SRD  = 4'd6;
   localparam logic [3:0] ST_RM_SWR  = 4'd7;
   localparam logic [3:0] ST_DIV     = 4'd8;
   localparam logic [3:0] ST_GET_RD  = 4'd9;
   localparam logic [3:0] ST_GET_CAP = 4'd10;
   localparam logic [3:0] ST_DONE    = 4'd11;

   logic [VALUE_WIDTH-1:0] mem [CAPACITY];
   logic [VALUE_WIDTH-1:0] rdata_ff;

   logic [3:0]             state_ff, state_in;
   logic [CW-1:0]          count_ff, count_in;
   logic [CW-1:0]          ptr_ff, ptr_in;
   logic [CW-1:0]          idx_ff, idx_in;
   logic [VALUE_WIDTH-1:0] val_ff, val_in;
   logic [31:0]            rd_ff, rd_in;
   logic                   ok_ff, ok_in;
   logic                   neg_ff, neg_in;
   logic                   rsp_valid_ff, rsp_valid_in;
   iss_pkg::rsp_type       rsp_ff, rsp_in;

   logic                   rd_en, wr_en;
   logic [CW-1:0]          rd_sel, wr_sel;
   logic [VALUE_WIDTH-1:0] wr_data;

   iss_pkg::div_ctl_type   div_ctl;
   logic                   div_done;
   logic [CW-1:0]          div_rem;

   logic                   accept;
   logic [63:0]            val_wide;
   logic [63:0]            rdata_wide;
   logic [31:0]            pos_mag;
   logic                   pos_neg;

   assign accept     = req_valid && !req_stall;
   assign req_stall  = (state_ff != ST_IDLE);
   assign val_wide   = {32'd0, req_data.value};
   assign rdata_wide = 64'(rdata_ff);
   assign pos_neg    = req_data.position[15];
   assign pos_mag    = {17'd0, req_data.position[14:0]};

   always_comb begin
      div_ctl.start    = accept && (req_data.op == iss_pkg::OP_GET) && (count_ff != '0);
      div_ctl.dividend = pos_neg ? 16'(-req_data.position) : 16'(req_data.position);
   end

   iss_mod_unit #(.CW(CW)) u_mod (
      .clock     (clock),
      .reset     (reset),
      .ctl       (div_ctl),
      .divisor   (count_ff),
      .done      (div_done),
      .remainder (div_rem)
   );

   always_comb begin
      state_in     = state_ff;
      count_in     = count_ff;
      ptr_in       = ptr_ff;
      idx_in       = idx_ff;
      val_in       = val_ff;
      rd_in        = rd_ff;
      ok_in        = ok_ff;
      neg_in       = neg_ff;
      rsp_valid_in = rsp_valid_ff && rsp_stall;
      rsp_in       = rsp_ff;
      rd_en        = 1'b0;
      wr_en        = 1'b0;
      rd_sel       = ptr_ff;
      wr_sel       = ptr_ff;
      wr_data      = rdata_ff;

      unique case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               ok_in    = 1'b0;
               rd_in    = '0;
               val_in   = val_wide[VALUE_WIDTH-1:0];
               ptr_in   = count_ff;
               neg_in   = pos_neg;
               state_in = ST_DONE;
               case (req_data.op) inside
                  iss_pkg::OP_INSERT, iss_pkg::OP_PREPEND, iss_pkg::OP_APPEND: begin
                     if (req_data.op == iss_pkg::OP_PREPEND) begin
                        idx_in = '0;
                     end else if (req_data.op == iss_pkg::OP_APPEND) begin
                        idx_in = count_ff;
                     end else begin
                        idx_in = CW'(pos_mag);
                     end
                     if (32'(count_ff) < 32'(CAPACITY) &&
                         (req_data.op != iss_pkg::OP_INSERT ||
                          (!pos_neg && pos_mag <= 32'(count_ff)))) begin
                        state_in = (count_ff > idx_in) ? ST_SH_RD : ST_WR_NEW;
                     end
                  end
                  iss_pkg::OP_REMOVE: begin
                     idx_in = CW'(pos_mag);
                     ptr_in = CW'(pos_mag);
                     if (!pos_neg && pos_mag < 32'(count_ff)) begin
                        state_in = ST_RM_RD;
                     end
                  end
                  iss_pkg::OP_GET: begin
                     if (count_ff != '0) begin
                        state_in = ST_DIV;
                     end
                  end
                  default: begin
                     state_in = ST_DONE;
                  end
               endcase
            end
         end
         ST_SH_RD: begin
            rd_en    = 1'b1;
            rd_sel   = ptr_ff - CW'(1);
            state_in = ST_SH_WR;
         end
         ST_SH_WR: begin
            wr_en    = 1'b1;
            ptr_in   = ptr_ff - CW'(1);
            state_in = (ptr_ff - CW'(1) > idx_ff) ? ST_SH_RD : ST_WR_NEW;
         end
         ST_WR_NEW: begin
            wr_en    = 1'b1;
            wr_sel   = idx_ff;
            wr_data  = val_ff;
            count_in = count_ff + CW'(1);
            ok_in    = 1'b1;
            state_in = ST_DONE;
         end
         ST_RM_RD: begin
            rd_en    = 1'b1;
            rd_sel   = idx_ff;
            state_in = ST_RM_CAP;
         end
         ST_RM_CAP: begin
            rd_in = rdata_wide[31:0];
            ok_in = 1'b1;
            if (32'(idx_ff) + 32'd1 < 32'(count_ff)) begin
               state_in = ST_RM_SRD;
            end else begin
               count_in = count_ff - CW'(1);
               state_in = ST_DONE;
            end
         end
         ST_RM_SRD: begin
            rd_en    = 1'b1;
            rd_sel   = ptr_ff + CW'(1);
            state_in = ST_RM_SWR;
         end
         ST_RM_SWR: begin
            wr_en  = 1'b1;
            ptr_in = ptr_ff + CW'(1);
            if (32'(ptr_ff) + 32'd2 < 32'(count_ff)) begin
               state_in = ST_RM_SRD;
            end else begin
               count_in = count_ff - CW'(1);
               state_in = ST_DONE;
            end
         end
         ST_DIV: begin
            if (div_done) begin
               ptr_in   = (neg_ff && div_rem != '0) ? count_ff - div_rem : div_rem;
               state_in = ST_GET_RD;
            end
         end
         ST_GET_RD: begin
            rd_en    = 1'b1;
            rd_sel   = ptr_ff;
            state_in = ST_GET_CAP;
         end
         ST_GET_CAP: begin
            rd_in    = rdata_wide[31:0];
            ok_in    = 1'b1;
            state_in = ST_DONE;
         end
         ST_DONE: begin
            if (!rsp_valid_ff || !rsp_stall) begin
               rsp_valid_in      = 1'b1;
               rsp_in.ok         = ok_ff;
               rsp_in.read_value = rd_ff;
               rsp_in.length     = 9'(count_ff);
               state_in          = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (rd_en) begin
         rdata_ff <= mem[rd_sel[AW-1:0]];
      end
      if (wr_en) begin
         mem[wr_sel[AW-1:0]] <= wr_data;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         count_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         count_ff     <= count_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      ptr_ff <= ptr_in;
      idx_ff <= idx_in;
      val_ff <= val_in;
      rd_ff  <= rd_in;
      ok_ff  <= ok_in;
      neg_ff <= neg_in;
      rsp_ff <= rsp_in;
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      32'(count_ff) <= 32'(CAPACITY))
      else $error("length above capacity");

   a_accept_idle: assert property (@(posedge clock) disable iff (reset)
      accept |=> state_ff != ST_IDLE)
      else $error("accepted beat left no work");

   a_insert_room: assert property (@(posedge clock) disable iff (reset)
      state_ff == ST_WR_NEW |-> 32'(count_ff) < 32'(CAPACITY))
      else $error("insert into full store");

endmodule

### tb/testbench.sv
// testbench: self-checking bench for indexed_sequence_store
// directed table, most rows with their own expected results, then fill/drain/mixed random phases vs a queue model
// depends on iss_pkg and the indexed_sequence_store rtl
`timescale 1ns / 100ps

module testbench;

   localparam logic [2:0] OP_RSVD5 = 3'd5;
   localparam logic [2:0] OP_RSVD6 = 3'd6;
   localparam logic [2:0] OP_RSVD7 = 3'd7;
   localparam int CAP            = 256;
   localparam int RANDOM_ITEMS   = 830;
   localparam int STALL_LIMIT    = 4000;
   localparam int HOLDOFF_CYCLES = 600;

   typedef struct {
      logic [2:0]  op;
      int          pos;
      logic [31:0] val;
      bit          typed;
      logic        ok;
      logic [31:0] rd;
      int          len;
   } row_type;

   logic             clock = 0;
   logic             reset = 1;
   logic             req_valid = 0;
   logic             req_stall;
   iss_pkg::req_type req_data = '0;
   logic             rsp_valid;
   logic             rsp_stall = 0;
   iss_pkg::rsp_type rsp_data;

   logic [31:0]      seq_image[$];
   iss_pkg::rsp_type pending_rsp[$];
   row_type          steps[$];
   bit               idle_on = 1;
   bit               holdoff_req = 0;
   bit               failed = 0;
   int               quiet_cycles = 0;
   int               n_beats = 0, n_results = 0, n_full = 0, max_len = 0;

   indexed_sequence_store dut (
      .clock(clock), .reset(reset),
      .req_valid(req_valid), .req_stall(req_stall), .req_data(req_data),
      .rsp_valid(rsp_valid), .rsp_stall(rsp_stall), .rsp_data(rsp_data)
   );

   always #5 clock = ~clock;

   function automatic iss_pkg::rsp_type apply_op(iss_pkg::req_type r);
      iss_pkg::rsp_type e;
      int               p, n, k;
      e = '0;
      p = r.position;
      n = seq_image.size();
      case (r.op) inside
         iss_pkg::OP_INSERT, iss_pkg::OP_PREPEND, iss_pkg::OP_APPEND: begin
            k = (r.op == iss_pkg::OP_INSERT) ? p : (r.op == iss_pkg::OP_PREPEND) ? 0 : n;
            if (n >= CAP) n_full++;
            if (n < CAP && k >= 0 && k <= n) begin
               seq_image.insert(k, r.value);
               e.ok = 1'b1;
            end
         end
         iss_pkg::OP_REMOVE: begin
            if (p >= 0 && p < n) begin
               e.read_value = seq_image[p];
               seq_image.delete(p);
               e.ok = 1'b1;
            end
         end
         iss_pkg::OP_GET: begin
            if (n > 0) begin
               k = p % n;
               if (k < 0) k += n;
               e.read_value = seq_image[k];
               e.ok = 1'b1;
            end
         end
         default: ;
      endcase
      e.length = 9'(seq_image.size());
      if (seq_image.size() > max_len) max_len = seq_image.size();
      return e;
   endfunction

   task automatic send_beat(logic [2:0] op, int pos, logic [31:0] val, bit typed,
                            iss_pkg::rsp_type typed_rsp);
      iss_pkg::req_type r;
      iss_pkg::rsp_type e;
      r.op = op;
      r.position = pos[15:0];
      r.value = val;
      if (idle_on && $urandom_range(0, 99) < 34)
         repeat ($urandom_range(1, 6)) @(negedge clock);
      req_valid = 1;
      req_data = r;
      do @(posedge clock); while (req_stall);
      e = apply_op(r);
      pending_rsp.push_back(typed ? typed_rsp : e);
      n_beats++;
      @(negedge clock);
      req_valid = 0;
   endtask

   task automatic add_row(logic [2:0] op, int pos, logic [31:0] val, bit typed = 0,
                          logic ok = 0, logic [31:0] rd = 0, int len = 0);
      row_type s;
      s.op = op; s.pos = pos; s.val = val; s.typed = typed;
      s.ok = ok; s.rd = rd; s.len = len;
      steps.push_back(s);
   endtask

   // receiver: random stalls plus one long hold-off on request
   initial begin
      forever begin
         @(negedge clock);
         if (holdoff_req) begin
            holdoff_req = 0;
            rsp_stall = 1;
            repeat (HOLDOFF_CYCLES) @(negedge clock);
         end
         rsp_stall = idle_on && ($urandom_range(0, 99) < 34);
      end
   end

   // result checker and watchdog
   always @(posedge clock) begin
      iss_pkg::rsp_type e;
      if (!reset) begin
         if ((req_valid && !req_stall) || (rsp_valid && !rsp_stall)) quiet_cycles <= 0;
         else quiet_cycles <= quiet_cycles + 1;
         if (quiet_cycles >= STALL_LIMIT) begin
            $display("CHECK FAILED");
            $finish;
         end
         if (rsp_valid && !rsp_stall) begin
            n_results++;
            if (pending_rsp.size() == 0) begin
               $error("result beat with nothing expected");
               failed = 1;
            end else begin
               e = pending_rsp.pop_front();
               if (rsp_data.ok !== e.ok) begin
                  $error("ok: expected %0b actual %0b", e.ok, rsp_data.ok);
                  failed = 1;
               end
               if (rsp_data.read_value !== e.read_value) begin
                  $error("read_value: expected %h actual %h", e.read_value,
                         rsp_data.read_value);
                  failed = 1;
               end
               if (rsp_data.length !== e.length) begin
                  $error("length: expected %0d actual %0d", e.length, rsp_data.length);
                  failed = 1;
               end
            end
         end
      end
   end

   initial begin
      iss_pkg::rsp_type t;
      logic [2:0] op;
      int pos, n, sel, mode;

      repeat (12) @(posedge clock);
      @(negedge clock);
      reset = 0;

      add_row(iss_pkg::OP_GET,     0,      32'h0,        1, 0, 0, 0);
      add_row(iss_pkg::OP_REMOVE,  0,      32'h0,        1, 0, 0, 0);
      add_row(iss_pkg::OP_INSERT,  1,      32'h1,        1, 0, 0, 0);
      add_row(iss_pkg::OP_INSERT,  -1,     32'h1,        1, 0, 0, 0);
      add_row(OP_RSVD5,            0,      32'hFFFFFFFF, 1, 0, 0, 0);
      add_row(OP_RSVD6,            -1,     32'h0,        1, 0, 0, 0);
      add_row(OP_RSVD7,            32767,  32'h0,        1, 0, 0, 0);
      add_row(iss_pkg::OP_APPEND,  -32768, 32'hFFFFFFFF, 1, 1, 0, 1);
      add_row(iss_pkg::OP_PREPEND, 32767,  32'h0,        1, 1, 0, 2);
      add_row(iss_pkg::OP_INSERT,  2,      32'h12345678, 1, 1, 0, 3);
      add_row(iss_pkg::OP_INSERT,  1,      32'hA5A5A5A5, 1, 1, 0, 4);
      add_row(iss_pkg::OP_GET,     -1,     32'h0,        1, 1, 32'h12345678, 4);
      add_row(iss_pkg::OP_GET,     32767,  32'h0);
      add_row(iss_pkg::OP_GET,     -32768, 32'h0);
      add_row(iss_pkg::OP_REMOVE,  4,      32'h0,        1, 0, 0, 4);
      add_row(iss_pkg::OP_REMOVE,  -1,     32'h0,        1, 0, 0, 4);
      add_row(iss_pkg::OP_INSERT,  5,      32'h0,        1, 0, 0, 4);
      add_row(iss_pkg::OP_REMOVE,  0,      32'h0,        1, 1, 0, 3);
      add_row(iss_pkg::OP_REMOVE,  2,      32'h0,        1, 1, 32'h12345678, 2);
      add_row(iss_pkg::OP_GET,     7,      32'h0);
      add_row(iss_pkg::OP_INSERT,  32767,  32'h5555AAAA, 1, 0, 0, 2);
      add_row(OP_RSVD7,            -32768, 32'hFFFFFFFF, 1, 0, 0, 2);

      foreach (steps[i]) begin
         t.ok = steps[i].ok;
         t.read_value = steps[i].rd;
         t.length = 9'(steps[i].len);
         send_beat(steps[i].op, steps[i].pos, steps[i].val, steps[i].typed, t);
      end

      // random phases: fill, drain, mixed, in turn
      for (int i = 0; i < RANDOM_ITEMS; i++) begin
         mode = (i / 140) % 3;
         idle_on = !(i >= 300 && i < 450);
         if (i == 200) holdoff_req = 1;
         if (i == 500) begin
            wait (pending_rsp.size() == 0);
            @(negedge clock);
         end
         n = seq_image.size();
         sel = $urandom_range(0, 99);
         if (sel < 3) op = 3'(OP_RSVD5 + $urandom_range(0, 2));
         else if (mode == 0) op = (sel < 80) ? ($urandom_range(0, 1) ? iss_pkg::OP_PREPEND
                                                                     : iss_pkg::OP_INSERT)
                                             : iss_pkg::OP_GET;
         else if (mode == 1) op = (sel < 80) ? iss_pkg::OP_REMOVE : iss_pkg::OP_GET;
         else op = 3'($urandom_range(0, 4));
         if (mode == 0 && sel >= 40 && sel < 80) op = iss_pkg::OP_APPEND;
         if ($urandom_range(0, 99) < 25) pos = $signed(16'($urandom_range(0, 65535)));
         else if (op == iss_pkg::OP_GET) pos = $urandom_range(0, 2 * n + 1) - n;
         else if (op == iss_pkg::OP_REMOVE) pos = (n > 0) ? $urandom_range(0, n - 1) : 0;
         else pos = $urandom_range(0, n);
         send_beat(op, pos, $urandom, 0, t);
      end

      wait (pending_rsp.size() == 0);
      repeat (600) @(posedge clock);
      $display("covered %0d beats, %0d results, peak length %0d, %0d inserts into a full store",
               n_beats, n_results, max_len, n_full);
      if (!failed && pending_rsp.size() == 0) begin
         $display("CHECK OK");
      end else begin
         $display("CHECK FAILED");
      end
      $finish;
   end

endmodule
